/* design/four_channel_pwm_group_defines.svh */
// assertion macros shared by the pwm group modules
`ifndef FOUR_CHANNEL_PWM_GROUP_DEFINES_SVH
`define FOUR_CHANNEL_PWM_GROUP_DEFINES_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FCPG_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FCPG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/fcpg_pkg.sv */
// types, constants and helpers for the four channel pwm group
package fcpg_pkg;

  localparam int CHANNELS = 4;
  localparam int PERIOD   = 100;
  localparam int DUTY_RST = 50;

  localparam int FUNC_W = 3;
  localparam int ID_W   = 3;
  localparam int CNT_W  = 7;
  localparam int STAT_W = 2;
  localparam int ASG_W  = 2;

  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 8;

  localparam logic [CNT_W-1:0] PERIOD_C   = CNT_W'(PERIOD);
  localparam logic [CNT_W-1:0] DUTY_RST_C = CNT_W'(DUTY_RST);
  localparam logic [ID_W:0]    ID_LIMIT   = (ID_W + 1)'(CHANNELS);

  // command codes
  typedef enum logic [FUNC_W-1:0] {
    FN_TICK     = 3'd0,
    FN_JOIN     = 3'd1,
    FN_REMOVE   = 3'd2,
    FN_RUN      = 3'd3,
    FN_PAUSE    = 3'd4,
    FN_SET_DUTY = 3'd5
  } func_t;

  // channel modes
  typedef enum logic [1:0] {
    MODE_FREE    = 2'd0,
    MODE_STOPPED = 2'd1,
    MODE_RUNNING = 2'd2
  } mode_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BAD_ID = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // command broadcast to one channel
  typedef struct packed {
    logic             fire;
    func_t            func;
    logic             hit;
    logic             join_sel;
    logic [CNT_W-1:0] duty;
  } chan_cmd_t;

  // what one channel reports back
  typedef struct packed {
    logic is_free;
    logic pin_nxt;
  } chan_stat_t;

  // saturate a duty value to the period
  function automatic logic [CNT_W-1:0] clamp_duty(input logic [CNT_W-1:0] d);
    return (d > PERIOD_C) ? PERIOD_C : d;
  endfunction

endpackage

/* design/fcpg_channel.sv */
// one pwm channel: mode, duty, period counter and pin level
`include "four_channel_pwm_group_defines.svh"

module fcpg_channel
  import fcpg_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chan_cmd_t  cmd,
  output chan_stat_t stat
);

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] duty_r, duty_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             pin_r, pin_nxt;
  logic [CNT_W-1:0] cnt_inc;

  assign cnt_inc = CNT_W'(cnt_r + 1'b1);

  // next state for the command at hand
  always_comb begin
    mode_nxt = mode_r;
    duty_nxt = duty_r;
    cnt_nxt  = cnt_r;
    pin_nxt  = pin_r;
    if (cmd.fire) begin
      unique case (cmd.func)
        FN_TICK: begin
          // period wrap wins over the duty match
          if (mode_r == MODE_RUNNING) begin
            if (cnt_inc == PERIOD_C) begin
              cnt_nxt = '0;
              pin_nxt = 1'b1;
            end else begin
              cnt_nxt = cnt_inc;
              if (cnt_inc == duty_r) begin
                pin_nxt = 1'b0;
              end
            end
          end
        end
        FN_JOIN: begin
          if (cmd.join_sel) begin
            mode_nxt = MODE_STOPPED;
            duty_nxt = cmd.duty;
            cnt_nxt  = '0;
            pin_nxt  = 1'b1;
          end
        end
        FN_REMOVE: begin
          // pin level is left as it is
          if (cmd.hit && mode_r != MODE_FREE) begin
            mode_nxt = MODE_FREE;
            duty_nxt = DUTY_RST_C;
            cnt_nxt  = '0;
          end
        end
        FN_RUN: begin
          if (cmd.hit && mode_r == MODE_STOPPED) begin
            mode_nxt = MODE_RUNNING;
          end
        end
        FN_PAUSE: begin
          if (cmd.hit && mode_r == MODE_RUNNING) begin
            mode_nxt = MODE_STOPPED;
            cnt_nxt  = '0;
            pin_nxt  = 1'b1;
          end
        end
        FN_SET_DUTY: begin
          if (cmd.hit && mode_r != MODE_FREE) begin
            duty_nxt = cmd.duty;
            cnt_nxt  = '0;
            pin_nxt  = 1'b1;
          end
        end
        default: begin
          // unused codes leave the channel alone
        end
      endcase
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_FREE;
      duty_r <= DUTY_RST_C;
      cnt_r  <= '0;
      pin_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      duty_r <= duty_nxt;
      cnt_r  <= cnt_nxt;
      pin_r  <= pin_nxt;
    end
  end

  assign stat.is_free = (mode_r == MODE_FREE);
  assign stat.pin_nxt = pin_nxt;

  // counter always restarts before the period, duty never passes it
  `FCPG_ASSERT_NOW(a_cnt_below_period, 1'b1, cnt_r < PERIOD_C, "count reached period")
  `FCPG_ASSERT_NOW(a_duty_saturated, 1'b1, duty_r <= PERIOD_C, "duty above period")
  // a free channel does not move its counter
  `FCPG_ASSERT_NEXT(a_free_cnt_zero, mode_r == MODE_FREE && cnt_r == '0,
                    mode_r != MODE_FREE || cnt_r == '0, "free channel counting")

endmodule

/* design/four_channel_pwm_group.sv */
// top level of the four channel pwm group
//
//  channel | dir | tdata bits                                   | tuser / tlast
//  in_     | in  | [2:0] func, [5:3] channel_id, [12:6] duty     | none
//  out_    | out | [3:0] pin_levels, [5:4] status, [7:6] assigned | none
//
// one beat in, one beat out; a beat may enter every cycle while results are being taken
// a beat passes the input register, then the channel update into the result register
// a stalled result holds the input register, which still takes one more beat
// synchronous active-low reset frees all channels, duty 50, count 0, pins low
`include "four_channel_pwm_group_defines.svh"

module four_channel_pwm_group
  import fcpg_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // func, channel_id, duty, zero pad
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata   // pin_levels, status, assigned_id
);

  // input register
  logic             in_vld_r;
  func_t            in_func_r;
  logic [ID_W-1:0]  in_id_r;
  logic [CNT_W-1:0] in_duty_r;

  // result register
  logic                out_vld_r;
  logic [CHANNELS-1:0] out_pins_r;
  status_t             out_stat_r;
  logic [ASG_W-1:0]    out_asg_r;

  logic                advance;
  logic                fire;
  logic [CHANNELS-1:0] free_vec;
  logic [CHANNELS-1:0] pin_nxt_vec;
  logic                any_free;
  logic [ASG_W-1:0]    pick;
  logic                id_cmd;
  logic                id_ok;
  status_t             stat_nxt;
  logic [ASG_W-1:0]    asg_nxt;
  logic [CNT_W-1:0]    duty_sat;
  chan_stat_t          ch_stat [CHANNELS];

  assign advance   = !out_vld_r || out_tready;
  assign fire      = in_vld_r && advance;
  assign in_tready = !in_vld_r || advance;

  // capture beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_func_r <= func_t'(in_tdata[2:0]);
      in_id_r   <= in_tdata[5:3];
      in_duty_r <= in_tdata[12:6];
    end
  end

  // lowest free slot for join
  always_comb begin
    any_free = 1'b0;
    pick     = '0;
    for (int i = CHANNELS - 1; i >= 0; i--) begin
      if (free_vec[i]) begin
        any_free = 1'b1;
        pick     = ASG_W'(i);
      end
    end
  end

  // command decode and status
  always_comb begin
    unique case (in_func_r) inside
      FN_REMOVE, FN_RUN, FN_PAUSE, FN_SET_DUTY: id_cmd = 1'b1;
      default:                                  id_cmd = 1'b0;
    endcase
  end

  assign id_ok    = ({1'b0, in_id_r} < ID_LIMIT);
  assign duty_sat = clamp_duty(in_duty_r);

  always_comb begin
    stat_nxt = ST_OK;
    asg_nxt  = '0;
    if (in_func_r == FN_JOIN) begin
      if (any_free) begin
        asg_nxt = pick;
      end else begin
        stat_nxt = ST_FULL;
      end
    end else if (id_cmd && !id_ok) begin
      stat_nxt = ST_BAD_ID;
    end
  end

  // channel slices
  for (genvar g = 0; g < CHANNELS; g++) begin : g_ch
    chan_cmd_t cmd;

    assign cmd.fire     = fire;
    assign cmd.func     = in_func_r;
    assign cmd.hit      = id_ok && (in_id_r == ID_W'(g));
    assign cmd.join_sel = any_free && (pick == ASG_W'(g));
    assign cmd.duty     = duty_sat;

    fcpg_channel u_ch (
      .clk  (clk),
      .rst_n(rst_n),
      .cmd  (cmd),
      .stat (ch_stat[g])
    );

    assign free_vec[g]    = ch_stat[g].is_free;
    assign pin_nxt_vec[g] = ch_stat[g].pin_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_pins_r <= pin_nxt_vec;
      out_stat_r <= stat_nxt;
      out_asg_r  <= asg_nxt;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {out_asg_r, out_stat_r, out_pins_r};

  // a processed beat always shows up as a result
  `FCPG_ASSERT_NEXT(a_fire_gives_result, fire, out_vld_r, "result lost")
  // input stalls only when both stages are full and the output is held
  `FCPG_ASSERT_NOW(a_stall_cause, !in_tready, in_vld_r && out_vld_r && !out_tready,
                   "input stalled without cause")
  // a successful join leaves its slot driven high
  `FCPG_ASSERT_NEXT(a_join_pin_high, fire && in_func_r == FN_JOIN && any_free,
                    out_pins_r[out_asg_r] && out_stat_r == ST_OK, "joined pin not high")
  // a full report never names a slot
  `FCPG_ASSERT_NOW(a_full_no_slot, out_vld_r && out_stat_r == ST_FULL, out_asg_r == '0,
                   "slot reported on full join")

endmodule
